// ===== rtl/circle_point_generator_defines.svh =====
// assertion helpers used by the rtl file cpg_back
`ifndef CIRCLE_POINT_GENERATOR_DEFINES_SVH
`define CIRCLE_POINT_GENERATOR_DEFINES_SVH

// same-cycle implication
`define CPG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cpg_pkg.sv =====
`timescale 1ns / 1ps
package cpg_pkg;

	localparam logic [30:0] HALF_PI_Q30 = 31'h6487ED51;
	localparam logic signed [33:0] INV_GAIN_Q30 = 34'sd652032874;

	typedef enum logic [1:0] {
		KIND_EMPTY  = 2'd0,
		KIND_SINGLE = 2'd1,
		KIND_MULTI  = 2'd2
	} kind_t;

	typedef struct packed {
		logic signed [23:0] cx;
		logic signed [23:0] cy;
		logic [6:0]         n;
		logic [22:0]        r;
		kind_t              kind;
	} req_t;

	// truncated q30 arctangent of 2^-k
	function automatic logic [29:0] atan_at(input logic [4:0] k);
		logic [29:0] a;
		case (k)
			5'd0:    a = 30'h3243F6A8;
			5'd1:    a = 30'h1DAC6705;
			5'd2:    a = 30'h0FADBAFC;
			5'd3:    a = 30'h07F56EA6;
			5'd4:    a = 30'h03FEAB76;
			5'd5:    a = 30'h01FFD55B;
			5'd6:    a = 30'h00FFFAAA;
			5'd7:    a = 30'h007FFF55;
			5'd8:    a = 30'h003FFFEA;
			5'd9:    a = 30'h001FFFFD;
			5'd10:   a = 30'h000FFFFF;
			5'd11:   a = 30'h0007FFFF;
			5'd12:   a = 30'h0003FFFF;
			5'd13:   a = 30'h0001FFFF;
			5'd14:   a = 30'h0000FFFF;
			5'd15:   a = 30'h00007FFF;
			5'd16:   a = 30'h00003FFF;
			5'd17:   a = 30'h00001FFF;
			5'd18:   a = 30'h00000FFF;
			5'd19:   a = 30'h000007FF;
			5'd20:   a = 30'h000003FF;
			5'd21:   a = 30'h000001FF;
			5'd22:   a = 30'h000000FF;
			5'd23:   a = 30'h0000007F;
			default: a = 30'h0;
		endcase
		return a;
	endfunction

	// divide by 2^30, ties away from zero
	function automatic logic signed [28:0] round_q30(input logic signed [57:0] p);
		logic        neg;
		logic [57:0] mag;
		logic [57:0] sum;
		logic [27:0] q;
		neg = p[57];
		mag = neg ? 58'(-p) : 58'(p);
		sum = mag + 58'(30'h20000000);
		q   = sum[57:30];
		return neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
	endfunction

	function automatic logic [23:0] sat24(input logic signed [29:0] v);
		logic [23:0] o;
		if (v > 30'sd8388607)
			o = 24'h7FFFFF;
		else if (v < -30'sd8388608)
			o = 24'h800000;
		else
			o = v[23:0];
		return o;
	endfunction

endpackage

// ===== rtl/cpg_front.sv =====
`timescale 1ns / 1ps
module cpg_front import cpg_pkg::*; #(
	parameter int MAX_POINTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] center_x,
	input  logic signed [23:0] center_y,
	input  logic [6:0]         point_count,
	input  logic [22:0]        circle_radius,
	output logic               req_valid,
	output req_t               req_head,
	input  logic               req_pop
);

	req_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	req_t       req_new;
	logic [6:0] n_sat;

	assign in_stall  = (cnt_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign req_valid = (cnt_q != 2'd0);
	assign pop       = req_pop && req_valid;
	assign req_head  = fifo_q[rd_ptr_q];

	// clamp the count and sort the request by kind
	always_comb begin
		n_sat = (point_count > 7'(MAX_POINTS)) ? 7'(MAX_POINTS) : point_count;
		req_new.cx = center_x;
		req_new.cy = center_y;
		req_new.n  = n_sat;
		req_new.r  = circle_radius;
		if (n_sat == 7'd0)
			req_new.kind = KIND_EMPTY;
		else if (n_sat == 7'd1)
			req_new.kind = KIND_SINGLE;
		else
			req_new.kind = KIND_MULTI;
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= req_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// ===== rtl/cpg_back.sv =====
`timescale 1ns / 1ps
`include "circle_point_generator_defines.svh"
module cpg_back import cpg_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  req_t               req_head,
	output logic               req_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] point_x,
	output logic signed [23:0] point_y,
	output logic [5:0]         point_index,
	output logic               is_last,
	output logic               is_empty
);

	localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_DIV  = 7'b0000010,
		ST_ZMUL = 7'b0000100,
		ST_CORD = 7'b0001000,
		ST_PMUL = 7'b0010000,
		ST_RND  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t             state_q;
	logic signed [23:0] cx_q, cy_q;
	logic [6:0]         n_q;
	logic [22:0]        r_q;
	logic               single_q, empty_q;
	logic [5:0]         idx_q;
	logic [6:0]         rem_q;
	logic [31:0]        quo_q;
	logic [4:0]         dcnt_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic [SW-1:0]      k_q;
	logic signed [57:0] prod_x_q, prod_y_q;
	logic [23:0]        px_q, py_q;
	logic               ov_q;
	logic signed [23:0] ox_q, oy_q;
	logic [5:0]         oidx_q;
	logic               olast_q, oempty_q;

	logic [7:0]         rem2;
	logic               ge;
	logic [60:0]        zprod;
	logic signed [33:0] dx, dy, at;
	logic signed [33:0] s_w, c_w;
	logic               out_free;
	logic               pt_last;

	assign rem2     = {rem_q, 1'b0};
	assign ge       = rem2 >= {1'b0, n_q};
	assign zprod    = quo_q[29:0] * HALF_PI_Q30;
	assign dx       = y_q >>> k_q;
	assign dy       = x_q >>> k_q;
	assign at       = $signed({4'b0, atan_at(5'(k_q))});
	assign out_free = !ov_q || !out_stall;
	assign pt_last  = single_q || (7'({1'b0, idx_q} + 7'd1) == n_q);
	assign req_pop  = (state_q == ST_IDLE);

	// quadrant from the top phase bits
	always_comb begin
		case (quo_q[31:30])
			2'd0:    begin c_w = x_q;  s_w = y_q;  end
			2'd1:    begin c_w = -y_q; s_w = x_q;  end
			2'd2:    begin c_w = -x_q; s_w = -y_q; end
			default: begin c_w = y_q;  s_w = -x_q; end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cx_q     <= req_head.cx;
				cy_q     <= req_head.cy;
				n_q      <= req_head.n;
				r_q      <= req_head.r;
				idx_q    <= 6'd0;
				rem_q    <= 7'd0;
				quo_q    <= 32'd0;
				dcnt_q   <= 5'd0;
				single_q <= (req_head.kind != KIND_MULTI);
				empty_q  <= (req_head.kind == KIND_EMPTY);
				px_q     <= (req_head.kind == KIND_EMPTY) ? 24'd0 : req_head.cx;
				py_q     <= (req_head.kind == KIND_EMPTY) ? 24'd0 : req_head.cy;
			end
			ST_DIV: begin
				rem_q  <= ge ? 7'(rem2 - {1'b0, n_q}) : rem2[6:0];
				quo_q  <= {quo_q[30:0], ge};
				dcnt_q <= dcnt_q + 5'd1;
			end
			ST_ZMUL: begin
				z_q <= $signed(34'(zprod[60:30]));
				x_q <= INV_GAIN_Q30;
				y_q <= 34'sd0;
				k_q <= '0;
			end
			ST_CORD: begin
				if (!z_q[33]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end
				k_q <= k_q + SW'(1);
			end
			ST_PMUL: begin
				prod_x_q <= $signed({1'b0, r_q}) * s_w;
				prod_y_q <= $signed({1'b0, r_q}) * c_w;
			end
			ST_RND: begin
				px_q <= sat24(30'(cx_q) + 30'(round_q30(prod_x_q)));
				py_q <= sat24(30'(cy_q) + 30'(round_q30(prod_y_q)));
			end
			ST_OUT: begin
				if (out_free && !pt_last) begin
					idx_q  <= idx_q + 6'd1;
					rem_q  <= {1'b0, idx_q + 6'd1};
					quo_q  <= 32'd0;
					dcnt_q <= 5'd0;
				end
			end
			default: ;
		endcase
		if (state_q == ST_OUT && out_free) begin
			ox_q     <= px_q;
			oy_q     <= py_q;
			oidx_q   <= idx_q;
			olast_q  <= pt_last;
			oempty_q <= empty_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid)
						state_q <= (req_head.kind == KIND_MULTI) ? ST_DIV : ST_OUT;
				end
				ST_DIV: begin
					if (dcnt_q == 5'd31)
						state_q <= ST_ZMUL;
				end
				ST_ZMUL: state_q <= ST_CORD;
				ST_CORD: begin
					if (k_q == SW'(CORDIC_STEPS - 1))
						state_q <= ST_PMUL;
				end
				ST_PMUL: state_q <= ST_RND;
				ST_RND:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free)
						state_q <= pt_last ? ST_IDLE : ST_DIV;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_OUT && out_free)
				ov_q <= 1'b1;
			else if (!out_stall)
				ov_q <= 1'b0;
		end
	end

	assign out_valid   = ov_q;
	assign point_x     = ox_q;
	assign point_y     = oy_q;
	assign point_index = oidx_q;
	assign is_last     = olast_q;
	assign is_empty    = oempty_q;

	`CPG_ASSERT_IMP(a_empty_zero, clk, arst_n, ov_q && oempty_q,
		ox_q == 24'sd0 && oy_q == 24'sd0 && olast_q && oidx_q == 6'd0, "empty item not zeroed")
	`CPG_ASSERT_IMP(a_rem_bound, clk, arst_n, state_q == ST_DIV,
		rem_q < n_q, "divider remainder out of range")
	`CPG_ASSERT_IMP(a_more_pending, clk, arst_n, ov_q && !olast_q,
		state_q != ST_IDLE, "request dropped before its last item")
	`CPG_ASSERT_NEXT(a_next_point, clk, arst_n, state_q == ST_OUT && out_free && !pt_last,
		state_q == ST_DIV, "next point not started")

endmodule

// ===== rtl/circle_point_generator.sv =====
`timescale 1ns / 1ps
// Generates point_count points evenly spaced on a circle around the center, one item
// per point, is_last on the last one; a zero count gives one empty item, a count of one
// gives the center. Each point passes in turn through the back end's bit-serial phase
// divider, one phase multiply, CORDIC_STEPS rotations of the shared CORDIC, one offset
// multiply, a rounding step and the output stage, after the request has been fetched;
// empty or single requests go from the fetch straight to the output stage.
// A two-deep request queue lets the input side take up to two requests ahead while the
// back end works.
module circle_point_generator import cpg_pkg::*; #(
	parameter int MAX_POINTS   = 64,
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] center_x,
	input  logic signed [23:0] center_y,
	input  logic [6:0]         point_count,
	input  logic [22:0]        circle_radius,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] point_x,
	output logic signed [23:0] point_y,
	output logic [5:0]         point_index,
	output logic               is_last,
	output logic               is_empty
);

	logic req_valid;
	req_t req_head;
	logic req_pop;

	cpg_front #(.MAX_POINTS(MAX_POINTS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.center_x      (center_x),
		.center_y      (center_y),
		.point_count   (point_count),
		.circle_radius (circle_radius),
		.req_valid     (req_valid),
		.req_head      (req_head),
		.req_pop       (req_pop)
	);

	cpg_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_head    (req_head),
		.req_pop     (req_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_index (point_index),
		.is_last     (is_last),
		.is_empty    (is_empty)
	);

endmodule

// ===== tb/circle_point_checker.sv =====
`timescale 1ns / 1ps
module circle_point_checker #(
	parameter int MAX_POINTS   = 64,
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [23:0] center_x,
	input  logic signed [23:0] center_y,
	input  logic [6:0]         point_count,
	input  logic [22:0]        circle_radius,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [23:0] point_x,
	input  logic signed [23:0] point_y,
	input  logic [5:0]         point_index,
	input  logic               is_last,
	input  logic               is_empty,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic [5:0]         idx;
		logic               last;
		logic               empty;
	} point_t;

	point_t expected_points[$];

	const longint atan_tab[24] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
		64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
		64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
	};

	assign pending = expected_points.size();

	function automatic longint div_round(input longint p);
		longint m;
		m = (p < 0) ? -p : p;
		m = (m + (64'sd1 <<< 29)) >>> 30;
		return (p < 0) ? -m : m;
	endfunction

	function automatic logic [23:0] clamp24(input longint v);
		if (v > 8388607)
			return 24'h7FFFFF;
		if (v < -8388608)
			return 24'h800000;
		return v[23:0];
	endfunction

	// rotation-mode cordic; returns {sin, cos} in q30
	task automatic sin_cos(input longint phase, output longint s, output longint c);
		longint z, x, y, dx, dy;
		int quad;
		quad = int'((phase >> 30) & 3);
		z = ((phase & 64'h3FFFFFFF) * 64'sd1686629713) >>> 30;
		x = 652032874;
		y = 0;
		for (int k = 0; k < CORDIC_STEPS && k < 24; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_tab[k];
			end else begin
				x += dx; y -= dy; z += atan_tab[k];
			end
		end
		case (quad)
			0: begin c = x; s = y; end
			1: begin c = -y; s = x; end
			2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endtask

	task automatic predict_points(input logic signed [23:0] cx, input logic signed [23:0] cy,
			input logic [6:0] cnt, input logic [22:0] rad);
		point_t p;
		longint n, s, c, r;
		n = (cnt > MAX_POINTS) ? MAX_POINTS : cnt;
		r = rad;
		if (n == 0) begin
			p = '{x: 0, y: 0, idx: 0, last: 1, empty: 1};
			expected_points.insert(expected_points.size(), p);
		end else if (n == 1) begin
			p = '{x: cx, y: cy, idx: 0, last: 1, empty: 0};
			expected_points.insert(expected_points.size(), p);
		end else begin
			for (longint i = 0; i < n; i++) begin
				sin_cos((i << 32) / n, s, c);
				p.x = clamp24(longint'(cx) + div_round(r * s));
				p.y = clamp24(longint'(cy) + div_round(r * c));
				p.idx = i[5:0];
				p.last = (i + 1 == n);
				p.empty = 0;
				expected_points.insert(expected_points.size(), p);
			end
		end
	endtask

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	initial fail_count = 0;

	always @(posedge clk) begin
		point_t e;
		if (arst_n) begin
			if (in_valid && !in_stall)
				predict_points(center_x, center_y, point_count, circle_radius);
			if (out_valid && !out_stall) begin
				if (expected_points.size() == 0) begin
					report("unexpected item");
				end else begin
					e = expected_points.pop_front();
					if (point_x !== e.x)
						report($sformatf("point_x %0d exp %0d", point_x, e.x));
					if (point_y !== e.y)
						report($sformatf("point_y %0d exp %0d", point_y, e.y));
					if (point_index !== e.idx)
						report($sformatf("point_index %0d exp %0d", point_index, e.idx));
					if (is_last !== e.last)
						report($sformatf("is_last %0b exp %0b", is_last, e.last));
					if (is_empty !== e.empty)
						report($sformatf("is_empty %0b exp %0b", is_empty, e.empty));
				end
			end
		end
	end

endmodule

// ===== tb/tb_circle_point_generator.sv =====
`timescale 1ns / 1ps
module tb_circle_point_generator;
	import cpg_pkg::*;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_stall;
	logic signed [23:0] center_x = 0;
	logic signed [23:0] center_y = 0;
	logic [6:0]         point_count = 0;
	logic [22:0]        circle_radius = 0;
	logic               out_valid;
	logic               out_stall = 0;
	logic signed [23:0] point_x;
	logic signed [23:0] point_y;
	logic [5:0]         point_index;
	logic               is_last;
	logic               is_empty;
	int                 fail_count;
	int                 pending;
	int                 cycle_count = 0;
	bit                 calm_out = 0;

	localparam int CYCLE_LIMIT = 2000000;

	always #5 clk = ~clk;

	circle_point_generator uut (.*);

	circle_point_checker chk (.*);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver stalls a random number of cycles before each item, none while calm_out is set
	initial begin
		int wait_n;
		@(posedge arst_n);
		forever begin
			wait_n = calm_out ? 0 : $urandom_range(0, 12);
			if (wait_n > 0) begin
				out_stall <= 1;
				repeat (wait_n) @(posedge clk);
			end
			out_stall <= 0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic send(input logic [23:0] cx, input logic [23:0] cy, input logic [6:0] n,
			input logic [22:0] r, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		center_x <= cx;
		center_y <= cy;
		point_count <= n;
		circle_radius <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	initial begin
		logic [6:0] n;
		bit calm;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: empty, single, extremes, saturation, oversize counts
		send(24'h000000, 24'h000000, 7'd0, 23'd0, 0);
		send(24'h123456, 24'hFEDCBA, 7'd0, 23'h7FFFFF, 0);
		send(24'h7FFFFF, 24'h800000, 7'd1, 23'h7FFFFF, 0);
		send(24'h800000, 24'h7FFFFF, 7'd1, 23'd0, 0);
		send(24'h000000, 24'h000000, 7'd2, 23'h7FFFFF, 0);
		send(24'h7FFFFF, 24'h7FFFFF, 7'd4, 23'h7FFFFF, 0);
		send(24'h800000, 24'h800000, 7'd4, 23'h7FFFFF, 0);
		send(24'h000100, 24'hFFFF00, 7'd3, 23'd256, 0);
		send(24'h000000, 24'h000000, 7'd64, 23'h400000, 0);
		send(24'h555555, 24'hAAAAAA, 7'd65, 23'h2AAAAA, 0);
		send(24'hAAAAAA, 24'h555555, 7'd127, 23'h555555, 1);
		send(24'h000000, 24'h000000, 7'd8, 23'd1, 1);
		send(24'h000000, 24'h000000, 7'd5, 23'd0, 0);
		send(24'hFFFFFF, 24'h000001, 7'd7, 23'd3, 0);
		for (int i = 0; i < 100; i++) begin
			case ($urandom_range(0, 9))
				0: n = 7'd0;
				1: n = 7'd1;
				2: n = 7'($urandom_range(65, 127));
				3: n = 7'($urandom_range(33, 64));
				default: n = 7'($urandom_range(2, 12));
			endcase
			calm = ($urandom_range(0, 9) == 0);
			calm_out = calm;
			send(24'($urandom), 24'($urandom), n,
				($urandom_range(0, 3) == 0) ? 23'($urandom) : 23'($urandom_range(0, 65535)),
				calm);
		end
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
